// ===== src/diff_drive_odometry_integrator_unit_defines.svh =====
// Assertion macros for the odometry integrator.
// Needs clk and rst_n in the scope of the including module.
`ifndef DIFF_DRIVE_ODOMETRY_INTEGRATOR_UNIT_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_INTEGRATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define DDOI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DDOI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ddoi_pkg.sv =====
// Shared constants and the CORDIC angle table of the odometry integrator.
// No dependencies.
`default_nettype none

package ddoi_pkg;

  localparam int TRIG_STEPS = 16;
  localparam int TAB_LEN    = 24;
  localparam int CORDIC_N   = (TRIG_STEPS < TAB_LEN) ? TRIG_STEPS : TAB_LEN;
  localparam int STEP_W     = $clog2(TAB_LEN);

  localparam logic signed [31:0] CORDIC_GAIN  = 32'sd652032874;
  localparam logic signed [31:0] TURN_PER_RAD = 32'sd683565276;
  localparam logic [15:0]        HALF_TRACK_RST = 16'd3736;

  function automatic logic signed [31:0] step_angle(input logic [STEP_W-1:0] idx);
    logic signed [31:0] a;
    case (idx)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== src/diff_drive_odometry_integrator_unit.sv =====
// Differential-drive dead-reckoning odometry integrator, top level.
// Uses ddoi_pkg and the assertion macros of the defines header.
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   request  | in_valid/in_stall, op, speeds, elapsed  | in
//   result   | out_valid/out_stall, pose, speeds, lamps| out
//   config   | cfg_wr_en/cfg_wr_data (half_track)      | in
//
// A velocity command passes through S_CMD_MUL and S_CMD_SIGN and gives no result.
// A tick runs one CORDIC step per cycle through a shared shift-add unit, then
// S_VC to S_PL on one 32x32 multiplier, and ends in S_HEAD.
// in_stall is high until the current request is done; a tick waits in its last
// step while the output register still holds an untaken result.
// Reset is synchronous: pose, speeds and wheel signs clear, half_track loads 3736.
`default_nettype none

`include "diff_drive_odometry_integrator_unit_defines.svh"

module diff_drive_odometry_integrator_unit
  import ddoi_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [15:0]         cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_op,
  input  wire logic signed [23:0]  in_lin_vel,
  input  wire logic signed [23:0]  in_ang_vel,
  input  wire logic [15:0]         in_elapsed,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [31:0]       out_pos_x,
  output logic signed [31:0]       out_pos_y,
  output logic [15:0]              out_yaw,
  output logic signed [23:0]       out_speed_now,
  output logic signed [23:0]       out_turn_now,
  output logic                     out_right_fwd_lamp,
  output logic                     out_right_back_lamp,
  output logic                     out_left_fwd_lamp,
  output logic                     out_left_back_lamp
);

  typedef enum logic [3:0] {
    S_IDLE, S_CMD_MUL, S_CMD_SIGN, S_CORD, S_VC, S_VCT, S_VS, S_VST,
    S_WD, S_PH, S_PL, S_HEAD
  } state_t;

  state_t             state_r, state_nxt;
  logic [15:0]        ht_r, ht_nxt;
  logic signed [31:0] x_r, x_nxt, y_r, y_nxt;
  logic [15:0]        heading_r, heading_nxt;
  logic signed [23:0] fwd_r, fwd_nxt, yaw_rate_r, yaw_rate_nxt;
  logic               rf_r, rf_nxt, rb_r, rb_nxt, lf_r, lf_nxt, lb_r, lb_nxt;
  logic [15:0]        dt_r, dt_nxt;
  logic signed [31:0] cx_r, cx_nxt, cy_r, cy_nxt, z_r, z_nxt;
  logic               flip_r, flip_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic [15:0]        pl_r, pl_nxt;
  logic [47:0]        acc_r, acc_nxt;

  logic               ov_r, ov_nxt;
  logic signed [31:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [15:0]        oyaw_r, oyaw_nxt;
  logic signed [23:0] ospd_r, ospd_nxt, oturn_r, oturn_nxt;
  logic [3:0]         olamp_r, olamp_nxt;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic               mul_en;
  logic signed [63:0] rnd30, rnd16;
  logic signed [31:0] vt, pstep;
  logic signed [31:0] sx, sy;
  logic               out_free;
  logic signed [42:0] vs43, tw43, rsum, lsum;
  logic [31:0]        ang;
  logic               flip_in;
  logic [47:0]        lo48, sum48;
  logic signed [32:0] xsum, ysum;

  assign rnd30 = prod_r + 64'sd536870912;
  assign rnd16 = prod_r + 64'sd32768;
  assign vt    = rnd30[61:30];
  assign pstep = rnd16[47:16];
  assign mul_p = mul_a * mul_b;
  assign sx    = cx_r >>> step_r;
  assign sy    = cy_r >>> step_r;
  assign out_free = !ov_r || !out_stall;
  assign vs43  = {{3{fwd_r[23]}}, fwd_r, 16'b0};
  assign tw43  = prod_r[42:0];
  assign rsum  = vs43 + tw43;
  assign lsum  = vs43 - tw43;
  assign ang   = {heading_r, 16'b0};
  assign flip_in = ang[31] ^ ang[30];
  assign lo48  = prod_r[47:0] + 48'h8000_0000_0000;
  assign sum48 = acc_r + {16'b0, lo48[47:16]};
  assign xsum  = {x_r[31], x_r} + {pstep[31], pstep};
  assign ysum  = {y_r[31], y_r} + {pstep[31], pstep};

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (state_r)
      S_CMD_MUL: begin
        mul_a = {{8{yaw_rate_r[23]}}, yaw_rate_r};
        mul_b = {16'b0, ht_r};
      end
      S_VC: begin
        mul_a = cx_r;
        mul_b = {{8{fwd_r[23]}}, fwd_r};
      end
      S_VS: begin
        mul_a = cy_r;
        mul_b = {{8{fwd_r[23]}}, fwd_r};
      end
      S_VCT, S_VST: begin
        mul_a = vt;
        mul_b = {16'b0, dt_r};
      end
      S_WD: begin
        mul_a = {{8{yaw_rate_r[23]}}, yaw_rate_r};
        mul_b = {16'b0, dt_r};
      end
      S_PH: begin
        mul_a = {{7{prod_r[40]}}, prod_r[40:16]};
        mul_b = TURN_PER_RAD;
      end
      S_PL: begin
        mul_a = {16'b0, pl_r};
        mul_b = TURN_PER_RAD;
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    ht_nxt       = cfg_wr_en ? cfg_wr_data : ht_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    heading_nxt  = heading_r;
    fwd_nxt      = fwd_r;
    yaw_rate_nxt = yaw_rate_r;
    rf_nxt       = rf_r;
    rb_nxt       = rb_r;
    lf_nxt       = lf_r;
    lb_nxt       = lb_r;
    dt_nxt       = dt_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    z_nxt        = z_r;
    flip_nxt     = flip_r;
    step_nxt     = step_r;
    prod_nxt     = mul_en ? mul_p : prod_r;
    pl_nxt       = pl_r;
    acc_nxt      = acc_r;
    ov_nxt       = (ov_r && !out_stall) ? 1'b0 : ov_r;
    ox_nxt       = ox_r;
    oy_nxt       = oy_r;
    oyaw_nxt     = oyaw_r;
    ospd_nxt     = ospd_r;
    oturn_nxt    = oturn_r;
    olamp_nxt    = olamp_r;
    in_stall     = (state_r != S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_op) begin
            fwd_nxt      = in_lin_vel;
            yaw_rate_nxt = in_ang_vel;
            state_nxt    = S_CMD_MUL;
          end else begin
            dt_nxt    = in_elapsed;
            flip_nxt  = flip_in;
            z_nxt     = flip_in ? (ang ^ 32'h8000_0000) : ang;
            cx_nxt    = CORDIC_GAIN;
            cy_nxt    = '0;
            step_nxt  = '0;
            state_nxt = S_CORD;
          end
        end
      end
      S_CMD_MUL: state_nxt = S_CMD_SIGN;
      S_CMD_SIGN: begin
        rf_nxt    = !rsum[42] && (rsum != '0);
        rb_nxt    = rsum[42];
        lf_nxt    = !lsum[42] && (lsum != '0);
        lb_nxt    = lsum[42];
        state_nxt = S_IDLE;
      end
      S_CORD: begin
        if (!z_r[31]) begin
          cx_nxt = cx_r - sy;
          cy_nxt = cy_r + sx;
          z_nxt  = z_r - step_angle(step_r);
        end else begin
          cx_nxt = cx_r + sy;
          cy_nxt = cy_r - sx;
          z_nxt  = z_r + step_angle(step_r);
        end
        if (step_r == STEP_W'(CORDIC_N - 1)) begin
          if (flip_r) begin
            cx_nxt = -cx_nxt;
            cy_nxt = -cy_nxt;
          end
          state_nxt = S_VC;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_VC:  state_nxt = S_VCT;
      S_VCT: state_nxt = S_VS;
      S_VS: begin
        if (xsum[32] != xsum[31]) begin
          x_nxt = xsum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          x_nxt = xsum[31:0];
        end
        state_nxt = S_VST;
      end
      S_VST: state_nxt = S_WD;
      S_WD: begin
        if (ysum[32] != ysum[31]) begin
          y_nxt = ysum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          y_nxt = ysum[31:0];
        end
        state_nxt = S_PH;
      end
      S_PH: begin
        pl_nxt    = prod_r[15:0];
        state_nxt = S_PL;
      end
      S_PL: begin
        acc_nxt   = prod_r[47:0];
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        if (out_free) begin
          heading_nxt = heading_r + sum48[47:32];
          ov_nxt      = 1'b1;
          ox_nxt      = x_r;
          oy_nxt      = y_r;
          oyaw_nxt    = heading_r + sum48[47:32];
          ospd_nxt    = fwd_r;
          oturn_nxt   = yaw_rate_r;
          olamp_nxt   = {rf_r, rb_r, lf_r, lb_r};
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ht_r       <= HALF_TRACK_RST;
      x_r        <= '0;
      y_r        <= '0;
      heading_r  <= '0;
      fwd_r      <= '0;
      yaw_rate_r <= '0;
      rf_r       <= 1'b0;
      rb_r       <= 1'b0;
      lf_r       <= 1'b0;
      lb_r       <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ht_r       <= ht_nxt;
      x_r        <= x_nxt;
      y_r        <= y_nxt;
      heading_r  <= heading_nxt;
      fwd_r      <= fwd_nxt;
      yaw_rate_r <= yaw_rate_nxt;
      rf_r       <= rf_nxt;
      rb_r       <= rb_nxt;
      lf_r       <= lf_nxt;
      lb_r       <= lb_nxt;
      ov_r       <= ov_nxt;
    end
    dt_r    <= dt_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    z_r     <= z_nxt;
    flip_r  <= flip_nxt;
    step_r  <= step_nxt;
    prod_r  <= prod_nxt;
    pl_r    <= pl_nxt;
    acc_r   <= acc_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    oyaw_r  <= oyaw_nxt;
    ospd_r  <= ospd_nxt;
    oturn_r <= oturn_nxt;
    olamp_r <= olamp_nxt;
  end

  assign out_valid           = ov_r;
  assign out_pos_x           = ox_r;
  assign out_pos_y           = oy_r;
  assign out_yaw             = oyaw_r;
  assign out_speed_now       = ospd_r;
  assign out_turn_now        = oturn_r;
  assign out_right_fwd_lamp  = olamp_r[3];
  assign out_right_back_lamp = olamp_r[2];
  assign out_left_fwd_lamp   = olamp_r[1];
  assign out_left_back_lamp  = olamp_r[0];

  `DDOI_ASSERT_NOW(a_step_range, state_r == S_CORD, step_r < STEP_W'(CORDIC_N),
                   "CORDIC step out of range")
  `DDOI_ASSERT_NEXT(a_head_hold, state_r == S_HEAD && ov_r && out_stall,
                    state_r == S_HEAD && $stable(heading_r),
                    "tick finished over a held result")
  `DDOI_ASSERT_NEXT(a_cmd_silent, state_r == S_CMD_SIGN && !ov_r, !ov_r,
                    "command produced a result")
  `DDOI_ASSERT_NOW(a_lamp_excl, out_valid,
                   !(out_right_fwd_lamp && out_right_back_lamp) &&
                   !(out_left_fwd_lamp && out_left_back_lamp),
                   "wheel lamps both lit")

endmodule

`default_nettype wire
